>>> sv/lstef_pkg.sv
// ----------------------------------------------------------------------------
// lstef_pkg
// Shared types and constants of the line-scan track edge finder.
// ----------------------------------------------------------------------------
package lstef_pkg;

  localparam int LINE_PIXELS_DEF     = 140;
  localparam int EDGE_LOW_LIMIT_DEF  = 5;
  localparam int EDGE_HIGH_LIMIT_DEF = 135;

  localparam logic [7:0] WHITE_VALUE  = 8'hA0;
  localparam logic [7:0] CENTRE_RESET = 8'd71;

  localparam logic [7:0] THRESHOLD_RESET  = 8'd100;
  localparam logic [7:0] STEP_MIN_RESET   = 8'd100;
  localparam logic [3:0] LINE_WIDTH_RESET = 4'd4;

  // search window: line_width is 4 bits, so at most 15 compared positions
  localparam int WIN     = 15;
  localparam int FILL_W  = $clog2(WIN + 1);

  localparam int QUEUE_DEPTH = 4;

  localparam int POS_W = 8;

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_LEFT_STEP,
    REG_RIGHT_STEP,
    REG_LINE_WIDTH
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       end_of_line;
  } lstef_in_t;

  typedef struct packed {
    logic [7:0] left_edge;
    logic [7:0] right_edge;
    logic [7:0] centre;
    logic       left_lost;
    logic       right_lost;
  } lstef_out_t;

  typedef struct packed {
    logic [7:0] binarize_threshold;
    logic [7:0] left_step_min;
    logic [7:0] right_step_min;
    logic [3:0] line_width;
  } lstef_cfg_t;

  typedef struct packed {
    logic             white;
    logic             we;
    logic [POS_W-1:0] addr;
    logic             eol;
  } lstef_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lstef_q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

endpackage

>>> sv/line_scan_track_edge_finder_core.sv
// ----------------------------------------------------------------------------
// line_scan_track_edge_finder_core
// Binarizes one camera line and finds the left and right track edges.
// ----------------------------------------------------------------------------
// A pixel transaction is taken whenever start is high and busy is low; busy
// rises only when the four-entry command queue is full. The search unit
// stores each queued pixel in the line store while idle. The end-of-line
// pixel starts the search, which runs one side after the other through a
// single read port of the line store: per side the compare window is filled,
// the last centre is tested and then every position stepped from it, and
// finally the result is formed and presented. The result is shown with done
// for one cycle and is never held back, so the receiver must take it then.
module line_scan_track_edge_finder_core #(
  parameter int LINE_PIXELS     = lstef_pkg::LINE_PIXELS_DEF,
  parameter int EDGE_LOW_LIMIT  = lstef_pkg::EDGE_LOW_LIMIT_DEF,
  parameter int EDGE_HIGH_LIMIT = lstef_pkg::EDGE_HIGH_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  lstef_pkg::lstef_in_t  item,
  output logic                  done,
  output lstef_pkg::lstef_out_t result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  lstef_pkg::lstef_cfg_t    cfg;
  lstef_pkg::lstef_cmd_t    push_cmd;
  lstef_pkg::lstef_cmd_t    head;
  lstef_pkg::lstef_q_stat_t q_stat;
  lstef_pkg::reg_idx_t      reg_idx;
  logic                     push;
  logic                     pop;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign busy    = q_stat.full;
  assign reg_idx = lstef_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.binarize_threshold <= lstef_pkg::THRESHOLD_RESET;
      cfg.left_step_min      <= lstef_pkg::STEP_MIN_RESET;
      cfg.right_step_min     <= lstef_pkg::STEP_MIN_RESET;
      cfg.line_width         <= lstef_pkg::LINE_WIDTH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lstef_pkg::REG_THRESHOLD:  cfg.binarize_threshold <= pwdata[7:0];
        lstef_pkg::REG_LEFT_STEP:  cfg.left_step_min      <= pwdata[7:0];
        lstef_pkg::REG_RIGHT_STEP: cfg.right_step_min     <= pwdata[7:0];
        lstef_pkg::REG_LINE_WIDTH: cfg.line_width         <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lstef_pkg::REG_THRESHOLD:  prdata = {24'b0, cfg.binarize_threshold};
      lstef_pkg::REG_LEFT_STEP:  prdata = {24'b0, cfg.left_step_min};
      lstef_pkg::REG_RIGHT_STEP: prdata = {24'b0, cfg.right_step_min};
      lstef_pkg::REG_LINE_WIDTH: prdata = {28'b0, cfg.line_width};
      default:                   prdata = '0;
    endcase
  end

  lstef_front #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .cfg    (cfg),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd)
  );

  lstef_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  lstef_back #(
    .LINE_PIXELS     (LINE_PIXELS),
    .EDGE_LOW_LIMIT  (EDGE_LOW_LIMIT),
    .EDGE_HIGH_LIMIT (EDGE_HIGH_LIMIT)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .cfg    (cfg),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

>>> sv/lstef_front.sv
// ----------------------------------------------------------------------------
// lstef_front
// Accepts pixel transactions, binarizes them and tracks the write position.
// ----------------------------------------------------------------------------
module lstef_front #(
  parameter int LINE_PIXELS = lstef_pkg::LINE_PIXELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  lstef_pkg::lstef_in_t   item,
  input  lstef_pkg::lstef_cfg_t  cfg,
  input  lstef_pkg::lstef_q_stat_t q_stat,
  output logic                   push,
  output lstef_pkg::lstef_cmd_t  cmd
);

  localparam int IDX_W = $clog2(LINE_PIXELS + 1);

  logic [IDX_W-1:0] widx;
  logic [IDX_W-1:0] widx_next;
  logic             room;

  assign room = widx < IDX_W'(LINE_PIXELS);
  assign push = start && !q_stat.full;

  always_comb begin
    cmd.white = item.pixel > cfg.binarize_threshold;
    cmd.we    = room;
    cmd.addr  = lstef_pkg::POS_W'(widx);
    cmd.eol   = item.end_of_line;
  end

  always_comb begin
    widx_next = widx;
    if (push) begin
      if (item.end_of_line) begin
        widx_next = '0;
      end else if (room) begin
        widx_next = widx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
    end else begin
      widx <= widx_next;
    end
  end

endmodule

>>> sv/lstef_queue.sv
// ----------------------------------------------------------------------------
// lstef_queue
// Short command queue between the classifying front and the search back end.
// ----------------------------------------------------------------------------
module lstef_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  lstef_pkg::lstef_cmd_t    push_cmd,
  input  logic                     pop,
  output lstef_pkg::lstef_cmd_t    head,
  output lstef_pkg::lstef_q_stat_t stat
);

  localparam int DEPTH = lstef_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lstef_pkg::lstef_cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = count == CNT_W'(DEPTH);
  assign stat.empty = count == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/lstef_back.sv
// ----------------------------------------------------------------------------
// lstef_back
// Stores the binarized line and runs the left and right edge searches.
// ----------------------------------------------------------------------------
module lstef_back #(
  parameter int LINE_PIXELS     = lstef_pkg::LINE_PIXELS_DEF,
  parameter int EDGE_LOW_LIMIT  = lstef_pkg::EDGE_LOW_LIMIT_DEF,
  parameter int EDGE_HIGH_LIMIT = lstef_pkg::EDGE_HIGH_LIMIT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lstef_pkg::lstef_cmd_t    head,
  input  lstef_pkg::lstef_q_stat_t q_stat,
  input  lstef_pkg::lstef_cfg_t    cfg,
  output logic                     pop,
  output logic                     done,
  output lstef_pkg::lstef_out_t    result
);

  localparam int AW   = $clog2(LINE_PIXELS);
  localparam int WIN  = lstef_pkg::WIN;
  localparam int FW   = lstef_pkg::FILL_W;
  localparam int PW   = lstef_pkg::POS_W;

  lstef_pkg::bk_state_t state;
  lstef_pkg::bk_state_t state_next;

  logic              line_mem [LINE_PIXELS];
  logic              side;
  logic [PW-1:0]     cur_p;
  logic signed [9:0] rd_addr;
  logic              rd_bit;
  logic              rd_vld;
  logic [WIN-1:0]    win;
  logic [FW-1:0]     fill;
  logic [PW-1:0]     le;
  logic              llost;
  logic [PW-1:0]     re;
  logic              rlost;
  logic [PW-1:0]     last_centre;

  logic              issue;
  logic              rd_ok;
  logic              eval;
  logic              lost_now;
  logic              found;
  logic              side_end;
  logic              restart;
  logic [7:0]        step_min;
  logic [8:0]        lim;
  logic [3:0]        n_win;
  logic [8:0]        edge_sum;
  logic [PW-1:0]     left_v;
  logic [PW-1:0]     right_v;

  assign rd_ok = (rd_addr >= 10'sd0) && (rd_addr < 10'(LINE_PIXELS));
  assign eval  = (state == lstef_pkg::BK_SCAN) && (fill == FW'(WIN));
  assign step_min = side ? cfg.right_step_min : cfg.left_step_min;

  always_comb begin
    if (side) begin
      lost_now = {1'b0, cur_p} >= 9'(EDGE_HIGH_LIMIT);
      lim      = 9'(EDGE_HIGH_LIMIT) - {1'b0, cur_p};
    end else begin
      lost_now = {1'b0, cur_p} <= 9'(EDGE_LOW_LIMIT);
      lim      = {1'b0, cur_p};
    end
    n_win = (lim < {5'b0, cfg.line_width}) ? lim[3:0] : cfg.line_width;
  end

  // trailing run of steps over the window must reach line_width - 1
  always_comb begin
    logic [4:0] need;
    logic [4:0] kk;
    logic       bp;
    logic       bq;
    logic       ck;
    logic       req;
    logic       all_ok;
    need   = {1'b0, cfg.line_width} - 5'd1;
    bp     = win[WIN-1];
    all_ok = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      kk = 5'(k);
      bq = win[WIN-1-k];
      if (step_min == 8'd0) begin
        ck = !(!bp && bq);
      end else if (step_min <= lstef_pkg::WHITE_VALUE) begin
        ck = bp && !bq;
      end else begin
        ck = 1'b0;
      end
      req = (kk < {1'b0, n_win}) && ((kk + need) >= {1'b0, n_win});
      all_ok = all_ok && (!req || ck);
    end
    if (cfg.line_width <= 4'd1) begin
      found = 1'b1;
    end else begin
      found = ({1'b0, n_win} >= need) && all_ok;
    end
  end

  assign side_end = eval && (lost_now || found);

  always_comb begin
    state_next = state;
    unique case (state)
      lstef_pkg::BK_IDLE: begin
        if (!q_stat.empty && head.eol) begin
          state_next = lstef_pkg::BK_SCAN;
        end
      end
      lstef_pkg::BK_SCAN: begin
        if (side_end && side) begin
          state_next = lstef_pkg::BK_DONE;
        end
      end
      lstef_pkg::BK_DONE: begin
        state_next = lstef_pkg::BK_IDLE;
      end
      default: state_next = lstef_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    unique case (state)
      lstef_pkg::BK_IDLE: pop   = !q_stat.empty;
      lstef_pkg::BK_SCAN: issue = !side_end;
      lstef_pkg::BK_DONE: ;
      default: ;
    endcase
  end

  assign restart = (pop && head.eol) || (side_end && !side);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lstef_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (pop && head.we) begin
      line_mem[head.addr[AW-1:0]] <= head.white;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && rd_ok) begin
      rd_bit <= line_mem[rd_addr[AW-1:0]];
    end else begin
      rd_bit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      fill   <= '0;
      side   <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (restart) begin
        fill <= '0;
        side <= !pop;
      end else if (rd_vld && (fill != FW'(WIN))) begin
        fill <= fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      win <= {win[WIN-2:0], rd_bit};
    end
    if (restart) begin
      cur_p   <= last_centre;
      rd_addr <= signed'({2'b00, last_centre});
    end else begin
      if (issue) begin
        rd_addr <= side ? rd_addr + 10'sd1 : rd_addr - 10'sd1;
      end
      if (eval && !lost_now && !found) begin
        cur_p <= side ? cur_p + PW'(1) : cur_p - PW'(1);
      end
    end
    if (side_end && !side) begin
      le    <= cur_p;
      llost <= lost_now;
    end
    if (side_end && side) begin
      re    <= cur_p;
      rlost <= lost_now;
    end
  end

  assign left_v   = llost ? PW'(EDGE_LOW_LIMIT) : le;
  assign right_v  = rlost ? PW'(EDGE_HIGH_LIMIT) : re;
  assign edge_sum = {1'b0, left_v} + {1'b0, right_v};

  always_ff @(posedge clk) begin
    if (state == lstef_pkg::BK_DONE) begin
      result.left_edge  <= left_v;
      result.right_edge <= right_v;
      result.centre     <= (llost && rlost) ? last_centre : edge_sum[8:1];
      result.left_lost  <= llost;
      result.right_lost <= rlost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      last_centre <= lstef_pkg::CENTRE_RESET;
    end else begin
      done <= state == lstef_pkg::BK_DONE;
      if ((state == lstef_pkg::BK_DONE) && !(llost && rlost)) begin
        last_centre <= edge_sum[8:1];
      end
    end
  end

endmodule

>>> sv/lstef_checker.sv
// ----------------------------------------------------------------------------
// lstef_checker
// Port-level checks of the edge finder results, bound to the top level.
// ----------------------------------------------------------------------------
module lstef_checker #(
  parameter int EDGE_LOW_LIMIT  = lstef_pkg::EDGE_LOW_LIMIT_DEF,
  parameter int EDGE_HIGH_LIMIT = lstef_pkg::EDGE_HIGH_LIMIT_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  done,
  input lstef_pkg::lstef_out_t result
);

  // a full search runs between two results, so results never come back to back
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result transactions");

  a_left_lost_limit: assert property (@(posedge clk) disable iff (rst)
    (done && result.left_lost) |-> (result.left_edge == 8'(EDGE_LOW_LIMIT)))
    else $error("lost left side without low limit");

  a_right_lost_limit: assert property (@(posedge clk) disable iff (rst)
    (done && result.right_lost) |-> (result.right_edge == 8'(EDGE_HIGH_LIMIT)))
    else $error("lost right side without high limit");

  a_centre_mean: assert property (@(posedge clk) disable iff (rst)
    (done && !(result.left_lost && result.right_lost)) |->
      ((({1'b0, result.left_edge} + {1'b0, result.right_edge}) >> 1)
        == {1'b0, result.centre}))
    else $error("centre is not the mean of the edges");

endmodule

bind line_scan_track_edge_finder_core lstef_checker #(
  .EDGE_LOW_LIMIT  (EDGE_LOW_LIMIT),
  .EDGE_HIGH_LIMIT (EDGE_HIGH_LIMIT)
) u_lstef_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);
